// ===== sv/raf_pkg.sv =====
// ---------------------------------------------------------------------------
// raf_pkg: shared types and constants for the rotation/affine transform
// Widths, register and function codes, and the words passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none

package raf_pkg;

	localparam int COORD_W         = 24;
	localparam int TRIG_W          = 16;
	localparam int COORD_FRAC_BITS = 8;
	localparam int TRIG_FRAC_BITS  = 14;
	localparam int FUNC_W          = 2;
	localparam int DIFF_W          = COORD_W + 1;          // x - offset, exact
	localparam int COEF_W          = TRIG_W + 1;           // holds -sin of the most negative code
	localparam int PROD_W          = DIFF_W + COEF_W;
	localparam int TERM_W          = PROD_W - TRIG_FRAC_BITS;
	localparam int SUM_W           = TERM_W + 2;           // two terms plus offset
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 32;
	localparam int REG_IDX_W       = PADDR_W - 2;

	// input function codes
	localparam logic [FUNC_W-1:0] FUNC_FWD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INV = 2'd1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_COS  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIN  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFX = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFY = 2'd3;

	localparam logic signed [TRIG_W-1:0] COS_RESET = TRIG_W'(64'sd1 <<< TRIG_FRAC_BITS);

	localparam logic signed [COORD_W-1:0] OUT_MAX = COORD_W'((64'sd1 <<< (COORD_W-1)) - 64'sd1);
	localparam logic signed [COORD_W-1:0] OUT_MIN = COORD_W'(-(64'sd1 <<< (COORD_W-1)));
	localparam logic signed [SUM_W-1:0]   SUM_MAX = SUM_W'((64'sd1 <<< (COORD_W-1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0]   SUM_MIN = SUM_W'(-(64'sd1 <<< (COORD_W-1)));
	localparam logic [SUM_W-1:0]          FRAC_MASK = SUM_W'((64'd1 << COORD_FRAC_BITS) - 64'd1);

	typedef enum logic [1:0] {
		MODE_FWD,
		MODE_INV,
		MODE_RECT
	} mode_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0]  cos_a;
		logic signed [TRIG_W-1:0]  sin_a;
		logic signed [COORD_W-1:0] off_x;
		logic signed [COORD_W-1:0] off_y;
	} cfg_t;

	// floored product terms: x result = xa + xb, y result = ya + yb
	typedef struct packed {
		mode_t                    mode;
		logic signed [TERM_W-1:0] xa0;
		logic signed [TERM_W-1:0] xa1;
		logic signed [TERM_W-1:0] xb0;
		logic signed [TERM_W-1:0] xb1;
		logic signed [TERM_W-1:0] ya0;
		logic signed [TERM_W-1:0] ya1;
		logic signed [TERM_W-1:0] yb0;
		logic signed [TERM_W-1:0] yb1;
	} terms_t;

endpackage

`default_nettype wire

// ===== sv/raf_cfg.sv =====
// ---------------------------------------------------------------------------
// raf_cfg: configuration registers
// APB-style register file for cosine, sine and the two offsets.
// ---------------------------------------------------------------------------
`default_nettype none

module raf_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [raf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [raf_pkg::PDATA_W-1:0] pwdata,
	output logic      [raf_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output raf_pkg::cfg_t                    cfg
);
	import raf_pkg::*;

	logic signed [TRIG_W-1:0]  cos_q;
	logic signed [TRIG_W-1:0]  sin_q;
	logic signed [COORD_W-1:0] offx_q;
	logic signed [COORD_W-1:0] offy_q;
	logic [REG_IDX_W-1:0]      idx;

	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= COS_RESET;
			sin_q  <= '0;
			offx_q <= '0;
			offy_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_COS:  cos_q  <= pwdata[TRIG_W-1:0];
				REG_SIN:  sin_q  <= pwdata[TRIG_W-1:0];
				REG_OFFX: offx_q <= pwdata[COORD_W-1:0];
				REG_OFFY: offy_q <= pwdata[COORD_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COS:  prdata = PDATA_W'(cos_q);
			REG_SIN:  prdata = PDATA_W'(sin_q);
			REG_OFFX: prdata = PDATA_W'(offx_q);
			REG_OFFY: prdata = PDATA_W'(offy_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.cos_a = cos_q;
	assign cfg.sin_a = sin_q;
	assign cfg.off_x = offx_q;
	assign cfg.off_y = offy_q;

endmodule

`default_nettype wire

// ===== sv/raf_prod.sv =====
// ---------------------------------------------------------------------------
// raf_prod: operand and product stages
// s1 forms offset differences and signed coefficients, s2 the eight products.
// ---------------------------------------------------------------------------
`default_nettype none

module raf_prod (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire raf_pkg::cfg_t                      cfg,
	input  wire logic                               up_valid,
	output logic                                    up_ready,
	input  wire logic        [raf_pkg::FUNC_W-1:0]  func,
	input  wire logic signed [raf_pkg::COORD_W-1:0] x0,
	input  wire logic signed [raf_pkg::COORD_W-1:0] y0,
	input  wire logic signed [raf_pkg::COORD_W-1:0] x1,
	input  wire logic signed [raf_pkg::COORD_W-1:0] y1,
	output logic                                    dn_valid,
	input  wire logic                               dn_ready,
	output raf_pkg::terms_t                         dn
);
	import raf_pkg::*;

	// stage 1 inputs
	mode_t                    mode;
	logic signed [DIFF_W-1:0] a0, a1, b0, b1;
	logic signed [COEF_W-1:0] c_co, s_co, ns_co;

	// stage 1 registers
	logic                     v_s1;
	mode_t                    mode_s1;
	logic signed [DIFF_W-1:0] a0_s1, a1_s1, b0_s1, b1_s1;
	logic signed [COEF_W-1:0] c_s1, kxb_s1, kya_s1;

	// stage 2
	logic                     v_s2;
	terms_t                   t_s2;
	logic signed [PROD_W-1:0] p_xa0, p_xa1, p_xb0, p_xb1, p_ya0, p_ya1, p_yb0, p_yb1;
	logic                     rdy_s1, rdy_s2;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_comb begin
		unique case (func)
			FUNC_FWD: mode = MODE_FWD;
			FUNC_INV: mode = MODE_INV;
			default:  mode = MODE_RECT;   // bit 1 set: box mode
		endcase
	end

	assign c_co  = COEF_W'(cfg.cos_a);
	assign s_co  = COEF_W'(cfg.sin_a);
	assign ns_co = -s_co;

	// forward uses the raw point; inverse works on differences
	assign a0 = (mode == MODE_FWD) ? DIFF_W'(x0) : DIFF_W'(x0) - DIFF_W'(cfg.off_x);
	assign b0 = (mode == MODE_FWD) ? DIFF_W'(y0) : DIFF_W'(y0) - DIFF_W'(cfg.off_y);
	assign a1 = DIFF_W'(x1) - DIFF_W'(cfg.off_x);
	assign b1 = DIFF_W'(y1) - DIFF_W'(cfg.off_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			mode_s1 <= mode;
			a0_s1   <= a0;
			a1_s1   <= a1;
			b0_s1   <= b0;
			b1_s1   <= b1;
			c_s1    <= c_co;
			kxb_s1  <= (mode == MODE_FWD) ? ns_co : s_co;
			kya_s1  <= (mode == MODE_FWD) ? s_co : ns_co;
		end
	end

	assign p_xa0 = PROD_W'(c_s1)   * PROD_W'(a0_s1);
	assign p_xa1 = PROD_W'(c_s1)   * PROD_W'(a1_s1);
	assign p_xb0 = PROD_W'(kxb_s1) * PROD_W'(b0_s1);
	assign p_xb1 = PROD_W'(kxb_s1) * PROD_W'(b1_s1);
	assign p_ya0 = PROD_W'(kya_s1) * PROD_W'(a0_s1);
	assign p_ya1 = PROD_W'(kya_s1) * PROD_W'(a1_s1);
	assign p_yb0 = PROD_W'(c_s1)   * PROD_W'(b0_s1);
	assign p_yb1 = PROD_W'(c_s1)   * PROD_W'(b1_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	// dropping the low fraction bits of a two's complement value floors it
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			t_s2.mode <= mode_s1;
			t_s2.xa0  <= p_xa0[PROD_W-1:TRIG_FRAC_BITS];
			t_s2.xa1  <= p_xa1[PROD_W-1:TRIG_FRAC_BITS];
			t_s2.xb0  <= p_xb0[PROD_W-1:TRIG_FRAC_BITS];
			t_s2.xb1  <= p_xb1[PROD_W-1:TRIG_FRAC_BITS];
			t_s2.ya0  <= p_ya0[PROD_W-1:TRIG_FRAC_BITS];
			t_s2.ya1  <= p_ya1[PROD_W-1:TRIG_FRAC_BITS];
			t_s2.yb0  <= p_yb0[PROD_W-1:TRIG_FRAC_BITS];
			t_s2.yb1  <= p_yb1[PROD_W-1:TRIG_FRAC_BITS];
		end
	end

	assign dn_valid = v_s2;
	assign dn       = t_s2;

endmodule

`default_nettype wire

// ===== sv/raf_box.sv =====
// ---------------------------------------------------------------------------
// raf_box: sum, bounding box, snap and clamp stages
// s3 adds terms (min/max per axis in box mode), s4 snaps and saturates.
// ---------------------------------------------------------------------------
`default_nettype none

module raf_box (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire raf_pkg::cfg_t               cfg,
	input  wire logic                        up_valid,
	output logic                             up_ready,
	input  wire raf_pkg::terms_t             up,
	output logic                             dn_valid,
	input  wire logic                        dn_ready,
	output logic signed [raf_pkg::COORD_W-1:0] out_x0,
	output logic signed [raf_pkg::COORD_W-1:0] out_y0,
	output logic signed [raf_pkg::COORD_W-1:0] out_x1,
	output logic signed [raf_pkg::COORD_W-1:0] out_y1,
	output logic                             saturated
);
	import raf_pkg::*;

	function automatic logic signed [TERM_W-1:0] tmin(logic signed [TERM_W-1:0] a,
	                                                 logic signed [TERM_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [TERM_W-1:0] tmax(logic signed [TERM_W-1:0] a,
	                                                 logic signed [TERM_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic is_clip(logic signed [SUM_W-1:0] v);
		return (v > SUM_MAX) || (v < SUM_MIN);
	endfunction

	function automatic logic signed [COORD_W-1:0] clip(logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SUM_MAX)
			r = OUT_MAX;
		else if (v < SUM_MIN)
			r = OUT_MIN;
		else
			r = v[COORD_W-1:0];
		return r;
	endfunction

	logic                     rect;
	logic signed [TERM_W-1:0] xa_lo, xa_hi, xb_lo, xb_hi, ya_lo, ya_hi, yb_lo, yb_hi;
	logic signed [SUM_W-1:0]  offx, offy;

	logic                     v_s3, rect_s3;
	logic signed [SUM_W-1:0]  lx_s3, hx_s3, ly_s3, hy_s3;

	logic signed [SUM_W-1:0]  fx0, fy0, fx1, fy1;
	logic                     v_s4, sat_s4;
	logic signed [COORD_W-1:0] x0_s4, y0_s4, x1_s4, y1_s4;
	logic                     rdy_s3, rdy_s4;

	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign up_ready = rdy_s3;

	// box extremes split per term since each corner sum is separable
	assign rect  = (up.mode == MODE_RECT);
	assign xa_lo = rect ? tmin(up.xa0, up.xa1) : up.xa0;
	assign xa_hi = tmax(up.xa0, up.xa1);
	assign xb_lo = rect ? tmin(up.xb0, up.xb1) : up.xb0;
	assign xb_hi = tmax(up.xb0, up.xb1);
	assign ya_lo = rect ? tmin(up.ya0, up.ya1) : up.ya0;
	assign ya_hi = tmax(up.ya0, up.ya1);
	assign yb_lo = rect ? tmin(up.yb0, up.yb1) : up.yb0;
	assign yb_hi = tmax(up.yb0, up.yb1);
	assign offx  = (up.mode == MODE_FWD) ? SUM_W'(cfg.off_x) : '0;
	assign offy  = (up.mode == MODE_FWD) ? SUM_W'(cfg.off_y) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && up_valid) begin
			rect_s3 <= rect;
			lx_s3   <= SUM_W'(xa_lo) + SUM_W'(xb_lo) + offx;
			hx_s3   <= SUM_W'(xa_hi) + SUM_W'(xb_hi);
			ly_s3   <= SUM_W'(ya_lo) + SUM_W'(yb_lo) + offy;
			hy_s3   <= SUM_W'(ya_hi) + SUM_W'(yb_hi);
		end
	end

	// floor: clear fraction; ceil: add fraction mask, then clear
	always_comb begin
		if (rect_s3) begin
			fx0 = lx_s3 & ~FRAC_MASK;
			fy0 = ly_s3 & ~FRAC_MASK;
			fx1 = (hx_s3 + FRAC_MASK) & ~FRAC_MASK;
			fy1 = (hy_s3 + FRAC_MASK) & ~FRAC_MASK;
		end else begin
			fx0 = lx_s3;
			fy0 = ly_s3;
			fx1 = '0;
			fy1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			x0_s4  <= clip(fx0);
			y0_s4  <= clip(fy0);
			x1_s4  <= clip(fx1);
			y1_s4  <= clip(fy1);
			sat_s4 <= is_clip(fx0) || is_clip(fy0) || is_clip(fx1) || is_clip(fy1);
		end
	end

	assign dn_valid  = v_s4;
	assign out_x0    = x0_s4;
	assign out_y0    = y0_s4;
	assign out_x1    = x1_s4;
	assign out_y1    = y1_s4;
	assign saturated = sat_s4;

endmodule

`default_nettype wire

// ===== sv/rotation_affine_transform_top.sv =====
// ---------------------------------------------------------------------------
// rotation_affine_transform_top: 2D rotation with offset on Q15.8 points
// Forward/inverse point mapping and inverse bounding box of a rectangle.
// ---------------------------------------------------------------------------
// Usage: while result_ready is high, one word enters and one result word
// leaves per clock. An accepted word passes s1 operand/offset subtract,
// s2 eight 17x25 multipliers, s3 term sums and box min/max, and s4 pixel
// snap and saturation, which is also the output register. Each stage
// holds its own valid bit and only stalls while its successor is full, so
// with result_ready held high item_ready is high too and the rate is one word
// per cycle. func 0 maps forward, func 1 inverse, func 2 and 3 return the
// snapped inverse bounding box of (x0,y0)-(x1,y1); out_x1/out_y1 are zero
// in the point modes. Products floor toward minus infinity, outputs clamp
// to the 24-bit range and raise saturated. Registers (cos_angle, sin_angle
// Q2.14; offset_x, offset_y Q15.8) sit at byte addresses 0, 4, 8, 12 and
// must only be written while no word is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module rotation_affine_transform_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic        [raf_pkg::PADDR_W-1:0] paddr,
	input  wire logic        [raf_pkg::PDATA_W-1:0] pwdata,
	output logic             [raf_pkg::PDATA_W-1:0] prdata,
	output logic                                    pready,
	// input words
	input  wire logic                               item_valid,
	output logic                                    item_ready,
	input  wire logic        [raf_pkg::FUNC_W-1:0]  func,
	input  wire logic signed [raf_pkg::COORD_W-1:0] x0,
	input  wire logic signed [raf_pkg::COORD_W-1:0] y0,
	input  wire logic signed [raf_pkg::COORD_W-1:0] x1,
	input  wire logic signed [raf_pkg::COORD_W-1:0] y1,
	// result words
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output logic signed      [raf_pkg::COORD_W-1:0] out_x0,
	output logic signed      [raf_pkg::COORD_W-1:0] out_y0,
	output logic signed      [raf_pkg::COORD_W-1:0] out_x1,
	output logic signed      [raf_pkg::COORD_W-1:0] out_y1,
	output logic                                    saturated
);
	import raf_pkg::*;

	cfg_t   cfg;
	terms_t terms;
	logic   terms_valid;
	logic   terms_ready;

	raf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// s1/s2: offsets, coefficients, products
	raf_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (item_valid),
		.up_ready (item_ready),
		.func     (func),
		.x0       (x0),
		.y0       (y0),
		.x1       (x1),
		.y1       (y1),
		.dn_valid (terms_valid),
		.dn_ready (terms_ready),
		.dn       (terms)
	);

	// s3/s4: sums, box, snap, clamp
	raf_box u_box (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up_valid  (terms_valid),
		.up_ready  (terms_ready),
		.up        (terms),
		.dn_valid  (result_valid),
		.dn_ready  (result_ready),
		.out_x0    (out_x0),
		.out_y0    (out_y0),
		.out_x1    (out_x1),
		.out_y1    (out_y1),
		.saturated (saturated)
	);

endmodule

`default_nettype wire

// ===== sv/raf_chk.sv =====
// ---------------------------------------------------------------------------
// raf_chk: port-level checks for rotation_affine_transform_top
// Bound to the top level; watches handshake and result ports only.
// ---------------------------------------------------------------------------
`default_nettype none

module raf_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               pready,
	input wire logic                               item_ready,
	input wire logic                               result_valid,
	input wire logic                               result_ready,
	input wire logic signed [raf_pkg::COORD_W-1:0] out_x0,
	input wire logic signed [raf_pkg::COORD_W-1:0] out_y0,
	input wire logic signed [raf_pkg::COORD_W-1:0] out_x1,
	input wire logic signed [raf_pkg::COORD_W-1:0] out_y1,
	input wire logic                               saturated
);
	import raf_pkg::*;

	// stalled result word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped while stalled");

	// stalled result word holds its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(out_x0) && $stable(out_y0)
			&& $stable(out_x1) && $stable(out_y1) && $stable(saturated))
		else $error("result word changed while stalled");

	// a free output side never back-pressures the input
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("input stalled with output ready");

	// saturation flag means some coordinate sits at a range limit
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
			out_x0 == OUT_MAX || out_x0 == OUT_MIN || out_y0 == OUT_MAX
			|| out_y0 == OUT_MIN || out_x1 == OUT_MAX || out_x1 == OUT_MIN
			|| out_y1 == OUT_MAX || out_y1 == OUT_MIN)
		else $error("saturated set without clamped output");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind rotation_affine_transform_top raf_chk u_raf_chk (.*);

`default_nettype wire

// ===== tb/sv/transform_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// transform_checker: result predictor and comparator for the rotation block
// Snoops register writes and both word channels, computes the mapping of
// each accepted input word and compares it with the returned result word.
// ---------------------------------------------------------------------------

module transform_checker
	import raf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic                      pready,
	input  wire logic [PADDR_W-1:0]        paddr,
	input  wire logic [PDATA_W-1:0]        pwdata,
	input  wire logic                      item_valid,
	input  wire logic                      item_ready,
	input  wire logic [FUNC_W-1:0]         func,
	input  wire logic signed [COORD_W-1:0] x0,
	input  wire logic signed [COORD_W-1:0] y0,
	input  wire logic signed [COORD_W-1:0] x1,
	input  wire logic signed [COORD_W-1:0] y1,
	input  wire logic                      result_valid,
	input  wire logic                      result_ready,
	input  wire logic signed [COORD_W-1:0] out_x0,
	input  wire logic signed [COORD_W-1:0] out_y0,
	input  wire logic signed [COORD_W-1:0] out_x1,
	input  wire logic signed [COORD_W-1:0] out_y1,
	input  wire logic                      saturated,
	output int                             mismatches,
	output int                             in_flight
);

	localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam longint COORD_LO = -(64'sd1 <<< (COORD_W - 1));

	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic               sat;
	} mapped_word_t;

	// shadow of the transform registers
	longint cos_q, sin_q, offx_q, offy_q;

	mapped_word_t pending_results[$];

	function automatic longint floor_prod(longint coef, longint v);
		return (coef * v) >>> TRIG_FRAC_BITS;
	endfunction

	function automatic longint pixel_floor(longint v);
		return (v >>> COORD_FRAC_BITS) <<< COORD_FRAC_BITS;
	endfunction

	function automatic longint pixel_ceil(longint v);
		return -pixel_floor(-v);
	endfunction

	function automatic bit out_of_range(longint v);
		return (v > COORD_HI) || (v < COORD_LO);
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(longint v);
		if (v > COORD_HI)
			return COORD_W'(COORD_HI);
		if (v < COORD_LO)
			return COORD_W'(COORD_LO);
		return COORD_W'(v);
	endfunction

	// offset removed exactly, then rotated by the negative angle
	function automatic void unrotate(longint x, longint y, output longint rx, output longint ry);
		longint dx, dy;
		dx = x - offx_q;
		dy = y - offy_q;
		rx = floor_prod(cos_q, dx) + floor_prod(sin_q, dy);
		ry = floor_prod(-sin_q, dx) + floor_prod(cos_q, dy);
	endfunction

	function automatic mapped_word_t map_word(logic [FUNC_W-1:0] f, longint ax, longint ay,
			longint bx, longint by);
		mapped_word_t m;
		longint rx, ry, cx, cy, lx, ly, hx, hy;
		int i;
		m = '0;
		if (f == FUNC_FWD || f == FUNC_INV) begin
			if (f == FUNC_FWD) begin
				rx = floor_prod(cos_q, ax) + floor_prod(-sin_q, ay) + offx_q;
				ry = floor_prod(sin_q, ax) + floor_prod(cos_q, ay) + offy_q;
			end else begin
				unrotate(ax, ay, rx, ry);
			end
			m.x0  = clamp_coord(rx);
			m.y0  = clamp_coord(ry);
			m.sat = out_of_range(rx) || out_of_range(ry);
		end else begin
			// box over the four unmapped corners, snapped before the clamp
			for (i = 0; i < 4; i++) begin
				unrotate(i[1] ? bx : ax, i[0] ? by : ay, cx, cy);
				if (i == 0) begin
					lx = cx; hx = cx; ly = cy; hy = cy;
				end else begin
					if (cx < lx) lx = cx;
					if (cx > hx) hx = cx;
					if (cy < ly) ly = cy;
					if (cy > hy) hy = cy;
				end
			end
			lx = pixel_floor(lx);
			ly = pixel_floor(ly);
			hx = pixel_ceil(hx);
			hy = pixel_ceil(hy);
			m.x0  = clamp_coord(lx);
			m.y0  = clamp_coord(ly);
			m.x1  = clamp_coord(hx);
			m.y1  = clamp_coord(hy);
			m.sat = out_of_range(lx) || out_of_range(ly) || out_of_range(hx) ||
				out_of_range(hy);
		end
		return m;
	endfunction

	task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mapped_word_t want;
		if (!arst_n) begin
			cos_q  = COS_RESET;
			sin_q  = 0;
			offx_q = 0;
			offy_q = 0;
			pending_results.delete();
			in_flight <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_COS:  cos_q  = $signed(pwdata[TRIG_W-1:0]);
					REG_SIN:  sin_q  = $signed(pwdata[TRIG_W-1:0]);
					REG_OFFX: offx_q = $signed(pwdata[COORD_W-1:0]);
					REG_OFFY: offy_q = $signed(pwdata[COORD_W-1:0]);
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				pending_results.push_back(map_word(func, x0, y0, x1, y1));
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with no input word outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("out_x0", want.x0, out_x0);
					check_field("out_y0", want.y0, out_y0);
					check_field("out_x1", want.x1, out_x1);
					check_field("out_y1", want.y1, out_y1);
					check_field("saturated", COORD_W'(want.sat), COORD_W'(saturated));
				end
			end
			in_flight <= pending_results.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for rotation_affine_transform_top
// Drives register setups and input words with random gaps and backpressure;
// a separate checker predicts and compares every result word.
// ---------------------------------------------------------------------------

module tb;
	import raf_pkg::*;

	// bit 1 alone selects the box mode, so code 3 behaves like code 2
	localparam logic [FUNC_W-1:0]  FUNC_BOX     = 2'd2;
	localparam logic [FUNC_W-1:0]  FUNC_BOX_ALT = 2'd3;
	localparam logic [COORD_W-1:0] C_MAX        = 24'h7FFFFF;
	localparam logic [COORD_W-1:0] C_MIN        = 24'h800000;
	localparam logic [TRIG_W-1:0]  TRIG_MOST_NEG = 16'h8000;
	localparam int MAX_WAIT      = 11;
	localparam int HOLD_CYCLES   = 300;  // long enough to back the pipe up into item_ready
	localparam int DRAIN_CYCLES  = 10;   // spare cycles once every result is back
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS   = 120;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      psel, penable, pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [PDATA_W-1:0]        pwdata;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      item_valid, item_ready;
	logic [FUNC_W-1:0]         func;
	logic signed [COORD_W-1:0] x0, y0, x1, y1;
	logic                      result_valid, result_ready;
	logic signed [COORD_W-1:0] out_x0, out_y0, out_x1, out_y1;
	logic                      saturated;
	int                        mismatches, in_flight;

	// idling switches per phase; hold_req asks the receiver for one long stall
	bit sender_idles, receiver_idles, hold_req;

	always #5 clk = ~clk;

	rotation_affine_transform_top dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.item_valid, .item_ready, .func, .x0, .y0, .x1, .y1,
		.result_valid, .result_ready, .out_x0, .out_y0, .out_x1, .out_y1, .saturated
	);

	transform_checker mapping_check (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.item_valid, .item_ready, .func, .x0, .y0, .x1, .y1,
		.result_valid, .result_ready, .out_x0, .out_y0, .out_x1, .out_y1, .saturated,
		.mismatches, .in_flight
	);

	function automatic int draw_wait(bit enabled);
		return enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	// mostly within +-1024 pixels so saturation stays the exception
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0:       return COORD_W'($urandom);
			1:       return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
			default: return COORD_W'($urandom_range(0, 1 << 19)) - COORD_W'(1 << 18);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] rand_offset();
		if ($urandom_range(0, 3) == 0)
			return COORD_W'($urandom);
		return COORD_W'($urandom_range(0, 1 << 17)) - COORD_W'(1 << 16);
	endfunction

	// Q2.14 in [-1.0, 1.0], exact +-1.0 now and then
	function automatic logic [TRIG_W-1:0] rand_trig();
		if ($urandom_range(0, 4) == 0)
			return ($urandom_range(0, 1) != 0) ? COS_RESET : -COS_RESET;
		return TRIG_W'($urandom_range(0, 32768)) - TRIG_W'(16384);
	endfunction

	// Called just after a rising edge; returns on the edge that accepts the word.
	// valid stays high afterwards unless the next call opens a gap.
	task automatic send_word(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] a,
			logic [COORD_W-1:0] b, logic [COORD_W-1:0] c, logic [COORD_W-1:0] d);
		int gap;
		gap = draw_wait(sender_idles);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func       <= f;
		x0         <= a;
		y0         <= b;
		x1         <= c;
		y1         <= d;
		// ready is settled by the falling edge, so sampling there is race free
		@(negedge clk);
		while (!item_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// stop offering words, let every result come back, then a few spare cycles
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(negedge clk);
		while (in_flight != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup cycle then access cycle; psel is left high for back-to-back writes
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_transform(logic [TRIG_W-1:0] c, logic [TRIG_W-1:0] s,
			logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
		wait_idle();
		write_reg(REG_COS, {{(PDATA_W-TRIG_W){c[TRIG_W-1]}}, c});
		write_reg(REG_SIN, {{(PDATA_W-TRIG_W){s[TRIG_W-1]}}, s});
		write_reg(REG_OFFX, {{(PDATA_W-COORD_W){ox[COORD_W-1]}}, ox});
		write_reg(REG_OFFY, {{(PDATA_W-COORD_W){oy[COORD_W-1]}}, oy});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// corner cases: range extremes, every mode, sub-pixel snapping,
	// reversed and zero-size boxes, code 3, junk in x1/y1 for point modes
	task automatic run_directed();
		send_word(FUNC_FWD, '0, '0, C_MAX, C_MIN);
		send_word(FUNC_FWD, C_MAX, C_MAX, '0, '0);
		send_word(FUNC_FWD, C_MIN, C_MIN, C_MAX, C_MAX);
		send_word(FUNC_INV, C_MAX, C_MIN, '0, '0);
		send_word(FUNC_INV, 24'h000180, 24'hFFFF80, 24'h123456, 24'h654321);
		send_word(FUNC_BOX, 24'h000100, 24'h000200, 24'h000A80, 24'h001040);
		send_word(FUNC_BOX, 24'h000A80, 24'h001040, 24'h000100, 24'h000200);
		send_word(FUNC_BOX, C_MIN, C_MIN, C_MAX, C_MAX);
		send_word(FUNC_BOX_ALT, 24'hFFFE40, 24'h0000C0, 24'h000301, 24'hFFFFFF);
		send_word(FUNC_BOX, 24'hFFFF40, 24'hFFFF40, 24'hFFFF40, 24'hFFFF40);
	endtask

	task automatic run_random(int count);
		int n;
		int pick;
		logic [FUNC_W-1:0] f;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			f = (pick < 3) ? FUNC_FWD : (pick < 6) ? FUNC_INV :
				(pick < 9) ? FUNC_BOX : FUNC_BOX_ALT;
			send_word(f, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	// result side: own stall per word, plus one long hold when requested
	initial begin
		int stall;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = draw_wait(receiver_idles);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(negedge clk);
			while (!result_valid) @(negedge clk);
			@(posedge clk);
		end
	end

	// input side and verdict
	initial begin
		int p;
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		item_valid <= 1'b0;
		func       <= FUNC_FWD;
		x0         <= '0;
		y0         <= '0;
		x1         <= '0;
		y1         <= '0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		hold_req       = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity transform straight out of reset
		run_directed();
		// extreme coefficients and offsets
		set_transform(-COS_RESET, COS_RESET, C_MAX, C_MIN);
		run_directed();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       set_transform(COS_RESET, -COS_RESET, C_MIN, C_MAX);
				1:       set_transform(TRIG_MOST_NEG, TRIG_MOST_NEG, rand_offset(), rand_offset());
				2:       set_transform('0, '0, rand_offset(), rand_offset());
				default: set_transform(rand_trig(), rand_trig(), rand_offset(), rand_offset());
			endcase
			// rotate through: receiver only idles, sender only idles, both idle
			sender_idles   = (p % 3) != 0;
			receiver_idles = (p % 3) != 1;
			if (p == 4) begin
				// back-to-back words against a long result stall: the pipe fills up
				sender_idles   = 1'b0;
				receiver_idles = 1'b0;
				hold_req       = 1'b1;
			end
			run_random(PHASE_WORDS);
		end

		wait_idle();
		if (mismatches == 0 && in_flight == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// slowest legal run is well under 400 us; this bound is several times that
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/raf_pkg.sv
sv/raf_cfg.sv
sv/raf_prod.sv
sv/raf_box.sv
sv/rotation_affine_transform_top.sv
sv/raf_chk.sv
tb/sv/transform_checker.sv
tb/sv/tb.sv
